### hw/rtl/circular_deque_defines.svh
// Assertion macros for the deque RTL, used by circular_deque.
// The macros expect a signal named clk, and CDQ_ASSERT also rst_n, in the scope where used.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Concurrent check on the rising clock edge, switched off while reset is low.
`define CDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CDQ_ASSERT(lbl, prop, msg)
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hw/rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    // Storage geometry.
    localparam int DEPTH   = 8;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int LEVEL_W = 4;

    // Register port geometry.
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int MODE_W    = 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_MODE = 1'b0;

    // Restriction modes; the fourth code acts as unrestricted.
    localparam logic [MODE_W-1:0] MODE_FREE         = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NO_FRONT_PUSH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NO_REAR_POP   = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_OVERFLOW    = 2'd1,
        ST_UNDERFLOW   = 2'd2,
        ST_NOT_ALLOWED = 2'd3
    } status_t;

    // Request item.
    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    // Response item.
    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] pop_value;
        logic [LEVEL_W-1:0]       level;
    } rsp_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic              push_front;
        logic              pop_front;
        logic              push_rear;
        logic [IDX_W-1:0]  wr_idx;
        logic [IDX_W-1:0]  rd_idx;
        logic [WORD_W-1:0] push_word;
    } cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/cdq_cell.sv
`default_nettype none

// One slot of the deque. Cell 0 holds the front word; the words sit packed
// toward cell 0, so a front push shifts the row up and a front pop shifts it down.
module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire cell_cmd_t         cmd,
    input  wire logic [WORD_W-1:0] left,
    input  wire logic [WORD_W-1:0] right,
    output logic      [WORD_W-1:0] word,
    output logic      [WORD_W-1:0] tap
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Select the new content of this slot.
    always_comb
    begin
        priority if (cmd.push_front)
        begin
            word_next = left;
        end
        else if (cmd.pop_front)
        begin
            word_next = right;
        end
        else if (cmd.push_rear && (cmd.wr_idx == idx))
        begin
            word_next = cmd.push_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

    // Only the rear cell drives the shared read bus.
    assign tap = (cmd.rd_idx == idx) ? word_reg : '0;

endmodule

`default_nettype wire

### hw/rtl/circular_deque.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------
// req      | req_valid/req_ready| op, push_value
// rsp      | rsp_valid/rsp_ready| status, pop_value, level
// config   | APB write          | restrict_mode at byte address 0
//
// One item is taken per cycle while intake runs; its response appears in the output register
// in the next cycle, and the chain of slot cells is updated at the same edge.
// A new item is taken while the output register is empty or being drained.
// A stall on rsp holds the response and stops intake; nothing is lost.
// Reset clears the fill count, the mode and the output valid; slots are not cleared.
`default_nettype none
`include "circular_deque_defines.svh"

module circular_deque
    import cdq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire req_t              req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rsp_t                   rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  cnt_dec;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              req_fire;
    logic              is_push;
    logic              refused;
    logic              step_ok;
    status_t           step_status;
    cell_cmd_t         cmd;

    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] cell_tap  [DEPTH];
    logic [WORD_W-1:0] rear_word;

    // Register port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FREE;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_MODE))
        begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1:2] == REG_MODE)
                  ? {{(DATA_W - MODE_W){1'b0}}, mode_reg} : '0;

    // Intake runs whenever the output register can take a response.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    // Classify the step: mode check first, then full and empty.
    assign is_push = (req.op == OP_PUSH_REAR) || (req.op == OP_PUSH_FRONT);
    assign refused = ((req.op == OP_PUSH_FRONT) && (mode_reg == MODE_NO_FRONT_PUSH))
                  || ((req.op == OP_POP_REAR) && (mode_reg == MODE_NO_REAR_POP));
    assign cnt_dec = cnt_reg - CNT_W'(1);

    always_comb
    begin
        priority if (refused)
        begin
            step_status = ST_NOT_ALLOWED;
        end
        else if (is_push && (cnt_reg == CNT_W'(DEPTH)))
        begin
            step_status = ST_OVERFLOW;
        end
        else if (!is_push && (cnt_reg == '0))
        begin
            step_status = ST_UNDERFLOW;
        end
        else
        begin
            step_status = ST_OK;
        end
    end

    assign step_ok = req_fire && (step_status == ST_OK);

    // Command broadcast to the cell row.
    always_comb
    begin
        cmd.push_front = step_ok && (req.op == OP_PUSH_FRONT);
        cmd.pop_front  = step_ok && (req.op == OP_POP_FRONT);
        cmd.push_rear  = step_ok && (req.op == OP_PUSH_REAR);
        cmd.wr_idx     = cnt_reg[IDX_W-1:0];
        cmd.rd_idx     = cnt_dec[IDX_W-1:0];
        cmd.push_word  = req.push_value;
    end

    // Row of slot cells linked to their neighbors; the end cells take the push word and zero.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = cmd.push_word;
        end
        else
        begin : g_inner_left
            assign left_word = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_inner_right
            assign right_word = cell_word[i+1];
        end

        cdq_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(i)),
            .cmd   (cmd),
            .left  (left_word),
            .right (right_word),
            .word  (cell_word[i]),
            .tap   (cell_tap[i])
        );
    end

    // Gather the rear word from the one cell that drives its tap.
    always_comb
    begin
        rear_word = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            rear_word = rear_word | cell_tap[j];
        end
    end

    // Fill count and response.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (step_ok)
        begin
            cnt_next = is_push ? (cnt_reg + CNT_W'(1)) : cnt_dec;
        end

        rsp_next.status    = step_status;
        rsp_next.pop_value = '0;
        if (step_ok && (req.op == OP_POP_FRONT))
        begin
            rsp_next.pop_value = cell_word[0];
        end
        else if (step_ok && (req.op == OP_POP_REAR))
        begin
            rsp_next.pop_value = rear_word;
        end
        rsp_next.level = LEVEL_W'(cnt_next);

        rsp_valid_next = rsp_valid_reg;
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks.
    `CDQ_ASSERT(a_cnt_range, cnt_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    `CDQ_ASSERT(a_level_tracks, req_fire |=> rsp_valid_reg && (rsp_reg.level == LEVEL_W'(cnt_reg)), "level differs from fill count")
    `CDQ_ASSERT(a_refused_holds, (req_fire && !step_ok) |=> $stable(cnt_reg), "refused step changed the fill count")
    `CDQ_ASSERT(a_pop_zero, (rsp_valid_reg && (rsp_reg.status != ST_OK)) |-> (rsp_reg.pop_value == '0), "refused step returned a word")
    `CDQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !rsp_valid_reg, "response valid after a reset edge")

endmodule

`default_nettype wire

### sim/tb_circular_deque.sv
`timescale 1ns / 100ps

module tb_circular_deque
    import cdq_pkg::*;
();

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int FILL_HOLD    = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int DIR_ROWS     = 24;

    // A second register slot that does not exist; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_SPARE  = 1'b1;
    localparam logic [ADDR_W-1:0]    MODE_ADDR  = {REG_MODE, 2'b00};
    localparam logic [ADDR_W-1:0]    SPARE_ADDR = {REG_SPARE, 2'b00};

    // The fourth mode code has no meaning and behaves as unrestricted.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam rsp_t UNTYPED = '0;

    localparam logic [MODE_W-1:0] PHASE_MODES [PHASES] = '{
        MODE_FREE, MODE_NO_FRONT_PUSH, MODE_NO_REAR_POP,
        MODE_UNUSED, MODE_NO_REAR_POP, MODE_FREE
    };

    // One directed step: an optional register write, then one item.
    typedef struct {
        bit                       cfg_wr;
        logic [ADDR_W-1:0]        cfg_addr;
        logic [MODE_W-1:0]        cfg_data;
        op_t                      op;
        logic signed [WORD_W-1:0] value;
        bit                       typed;
        rsp_t                     result;
    } step_row_t;

    // Directed steps: empty pops, extreme words, full pushes, refused operations,
    // the unused mode code and a write to the missing register.
    step_row_t dir_tbl [DIR_ROWS] = '{
        '{1'b1, MODE_ADDR, MODE_FREE, OP_POP_FRONT, 32'h0, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_POP_REAR, 32'h0, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_REAR, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h0, 4'd1}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 4'd2}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_REAR, 32'h0000_0000, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_REAR, 32'h5555_5555, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_REAR, 32'h0000_0001, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_REAR, 32'h1234_5678, 1'b1,
          '{ST_OVERFLOW, 32'h0, 4'd8}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_FRONT, 32'h8765_4321, 1'b1,
          '{ST_OVERFLOW, 32'h0, 4'd8}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_POP_FRONT, 32'h0, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_POP_REAR, 32'h0, 1'b0, UNTYPED},
        '{1'b1, MODE_ADDR, MODE_NO_FRONT_PUSH, OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b1,
          '{ST_NOT_ALLOWED, 32'h0, 4'd6}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_REAR, 32'hF0F0_F0F0, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_POP_REAR, 32'h0, 1'b0, UNTYPED},
        '{1'b1, MODE_ADDR, MODE_NO_REAR_POP, OP_POP_REAR, 32'h0, 1'b1,
          '{ST_NOT_ALLOWED, 32'h0, 4'd6}},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_PUSH_FRONT, 32'h3C3C_3C3C, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_POP_FRONT, 32'h0, 1'b0, UNTYPED},
        '{1'b1, MODE_ADDR, MODE_UNUSED, OP_PUSH_FRONT, 32'hC3C3_C3C3, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_POP_REAR, 32'h0, 1'b0, UNTYPED},
        '{1'b1, SPARE_ADDR, MODE_NO_FRONT_PUSH, OP_PUSH_FRONT, 32'h6996_6996, 1'b0, UNTYPED},
        '{1'b0, MODE_ADDR, MODE_FREE, OP_POP_REAR, 32'h0, 1'b0, UNTYPED}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow deque used to predict every response.
    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       shadow_front;
    int                       shadow_back;
    int                       shadow_count;
    logic [MODE_W-1:0]        shadow_mode;

    rsp_t awaited_rsp [$];

    int mismatches;
    int n_items;
    int n_checked;
    int n_overflow;
    int n_underflow;
    int n_refused;
    int n_mode_writes;
    int stall_cycles;
    bit hold_request;
    bit quiet_phase;

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    circular_deque u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Applies one operation to the shadow deque and returns the response it should give.
    function automatic rsp_t deque_step(op_t op, logic signed [WORD_W-1:0] value);
        rsp_t r;
        bit   is_push;
        r = '0;
        is_push = (op == OP_PUSH_REAR) || (op == OP_PUSH_FRONT);
        if ((op == OP_PUSH_FRONT && shadow_mode == MODE_NO_FRONT_PUSH) ||
            (op == OP_POP_REAR && shadow_mode == MODE_NO_REAR_POP))
        begin
            r.status = ST_NOT_ALLOWED;
        end
        else if (is_push && shadow_count >= DEPTH)
        begin
            r.status = ST_OVERFLOW;
        end
        else if (!is_push && shadow_count == 0)
        begin
            r.status = ST_UNDERFLOW;
        end
        else
        begin
            r.status = ST_OK;
            unique case (op)
                OP_PUSH_REAR:
                begin
                    shadow_words[shadow_back] = value;
                    shadow_back = (shadow_back + 1) % DEPTH;
                    shadow_count++;
                end
                OP_PUSH_FRONT:
                begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_words[shadow_front] = value;
                    shadow_count++;
                end
                OP_POP_FRONT:
                begin
                    r.pop_value = shadow_words[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
                default:
                begin
                    shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
                    r.pop_value = shadow_words[shadow_back];
                    shadow_count--;
                end
            endcase
        end
        r.level = LEVEL_W'(shadow_count);
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] response %0d: %s", $time, n_checked, what);
    endtask

    // Offers one item, waits for it to be taken, records its expected response.
    task automatic send_item(op_t op, logic signed [WORD_W-1:0] value, bit typed,
                             rsp_t typed_rsp);
        rsp_t predicted;
        int   gap;
        req_valid <= 1'b1;
        req       <= '{op: op, push_value: value};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = deque_step(op, value);
        awaited_rsp.push_back(typed ? typed_rsp : predicted);
        n_items++;
        case (predicted.status)
            ST_OVERFLOW:    n_overflow++;
            ST_UNDERFLOW:   n_underflow++;
            ST_NOT_ALLOWED: n_refused++;
            default:        ;
        endcase
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every response is back.
    task automatic settle();
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup phase, access phase held until pready, then the bus back at rest.
    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[ADDR_W-1:2] == REG_MODE)
        begin
            shadow_mode = data[MODE_W-1:0];
            n_mode_writes++;
        end
        @(posedge clk);
    endtask

    // Response side: random stalls, plus one long hold to back the block up.
    initial
    begin : rsp_sink
        int gap_left;
        int run_left;
        bit hold_done;
        gap_left  = 0;
        run_left  = 0;
        hold_done = 1'b0;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                gap_left  = FILL_HOLD;
                run_left  = 1;
            end
            if (gap_left == 0 && run_left == 0)
            begin
                gap_left = pick_gap();
                run_left = $urandom_range(1, 16);
            end
            if (gap_left != 0)
            begin
                rsp_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                run_left--;
            end
        end
    end

    // Compares each response with the oldest expected one.
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response status %0d pop %0d level %0d",
                                          rsp.status, rsp.pop_value, rsp.level));
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp.status, want.status));
                if (rsp.pop_value !== want.pop_value)
                    report_mismatch($sformatf("pop_value got %0d want %0d",
                                              rsp.pop_value, want.pop_value));
                if (rsp.level !== want.level)
                    report_mismatch($sformatf("level got %0d want %0d",
                                              rsp.level, want.level));
            end
            n_checked++;
        end
    end

    // Ends the run if no item moves on either channel for too long.
    always @(posedge clk)
    begin : watchdog
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Main stimulus: reset, directed steps, then random phases per mode.
    initial
    begin : stimulus
        int                       p;
        int                       k;
        int                       burst_left;
        int                       push_pct;
        op_t                      op;
        logic signed [WORD_W-1:0] value;
        logic [DATA_W-1:0]        wdata;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        shadow_front = 0;
        shadow_back  = 0;
        shadow_count = 0;
        shadow_mode  = MODE_FREE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed steps.
        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].cfg_wr)
            begin
                settle();
                reg_write(dir_tbl[i].cfg_addr, DATA_W'(dir_tbl[i].cfg_data));
            end
            send_item(dir_tbl[i].op, dir_tbl[i].value, dir_tbl[i].typed, dir_tbl[i].result);
        end

        // Random phases: bursts that lean toward pushes, toward pops or neither, so the deque
        // keeps running into full and empty.
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            wdata = $urandom;
            wdata[MODE_W-1:0] = PHASE_MODES[p];
            reg_write(MODE_ADDR, wdata);
            if ($urandom_range(0, 1))
                reg_write(SPARE_ADDR, $urandom);
            quiet_phase = (p == 2);
            burst_left  = 0;
            push_pct    = 50;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 1 && k == 40)
                    hold_request = 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    case ($urandom_range(0, 2))
                        0:       push_pct = 15;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                burst_left--;
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                else
                    op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
                case ($urandom_range(0, 11))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = 32'h0000_0000;
                    3:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                send_item(op, value, 1'b0, UNTYPED);
            end
        end
        settle();

        $display("Ran %0d items through %0d mode settings, %0d responses checked.",
                 n_items, n_mode_writes, n_checked);
        $display("Seen: %0d overflows, %0d underflows, %0d refused by mode.",
                 n_overflow, n_underflow, n_refused);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cell.sv
hw/rtl/circular_deque.sv
sim/tb_circular_deque.sv
